// ----- hw/rtl/abt_pkg.sv -----
// Shared types and constants for the array-based binary search tree block.
// Used by abt_front, abt_back and array_bst_insert_traverse; no dependencies.
`timescale 1ns / 1ps

package abt_pkg;

    // Field widths of the stream payloads.
    localparam int KEY_W      = 32;
    localparam int ORDER_W    = 2;
    localparam int IN_USER_W  = 1 + ORDER_W;
    localparam int OUT_USER_W = 2;

    // Default tree size (slots of the implicit array).
    localparam int TREE_NODES_DEF = 63;

    // Command queue between front and back; depth must be a power of two.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Input kind and traversal order codes.
    localparam logic             KIND_INSERT   = 1'b0;
    localparam logic             KIND_TRAVERSE = 1'b1;
    localparam logic [ORDER_W-1:0] ORD_PRE  = 2'd0;
    localparam logic [ORDER_W-1:0] ORD_IN   = 2'd1;
    localparam logic [ORDER_W-1:0] ORD_POST = 2'd2;

    // Commands after classification by the front.
    typedef enum logic [2:0] {
        CMD_INSERT,
        CMD_NOP,
        CMD_PRE,
        CMD_IN,
        CMD_POST
    } t_cmd;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_INSERTED,
        STAT_FULL,
        STAT_KEY,
        STAT_EMPTY
    } t_status;

    // Head of the command queue as seen by the back.
    typedef struct packed {
        logic             valid;
        t_cmd             cmd;
        logic [KEY_W-1:0] key;
    } t_queue_head;

    // Back state machine.
    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CMP,
        S_INS_WR,
        S_TRV_STEP,
        S_TRV_EMIT,
        S_TRV_FIN
    } t_state;

    // How the traversal arrived at the current slot.
    typedef enum logic [1:0] {
        PH_ENTER,
        PH_FROM_LEFT,
        PH_FROM_RIGHT
    } t_phase;

endpackage

// ----- hw/rtl/abt_front.sv -----
// Front end: accepts input beats, classifies them into commands and queues them.
// Depends on abt_pkg.
`timescale 1ns / 1ps

module abt_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [abt_pkg::KEY_W-1:0]    i_in_key,
    input  logic                         i_in_kind,
    input  logic [abt_pkg::ORDER_W-1:0]  i_in_order,
    output abt_pkg::t_queue_head         o_head,
    input  logic                         i_pop
);
    import abt_pkg::*;

    logic [KEY_W-1:0]  r_q_key [QUEUE_DEPTH];
    t_cmd              r_q_cmd [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;
    logic              push;
    logic              pop;
    t_cmd              in_cmd;

    // Map kind, key and order onto one back-end command.
    function automatic t_cmd classify(logic kind, logic [KEY_W-1:0] key,
                                      logic [ORDER_W-1:0] order);
        t_cmd c;
        if (kind == KIND_INSERT) begin
            c = (key == '0) ? CMD_NOP : CMD_INSERT;
        end else begin
            unique case (order)
                ORD_IN:   c = CMD_IN;
                ORD_POST: c = CMD_POST;
                default:  c = CMD_PRE;
            endcase
        end
        return c;
    endfunction

    assign in_cmd     = classify(i_in_kind, i_in_key, i_in_order);
    assign o_in_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign push       = i_in_valid && o_in_ready;
    assign pop        = i_pop && (r_count != '0);

    // Head of the queue.
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_q_cmd[r_rd_ptr];
    assign o_head.key   = r_q_key[r_rd_ptr];

    assign n_count = r_count + QCNT_W'(push) - QCNT_W'(pop);

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
        end
    end

    // Queue payload storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_cmd[r_wr_ptr] <= in_cmd;
            r_q_key[r_wr_ptr] <= i_in_key;
        end
    end

endmodule

// ----- hw/rtl/abt_back.sv -----
// Back end: node store, insert walk, traversal sequencer and output register.
// Depends on abt_pkg; fed by abt_front through a t_queue_head.
`timescale 1ns / 1ps

module abt_back #(
    parameter int TREE_NODES = abt_pkg::TREE_NODES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  abt_pkg::t_queue_head      i_head,
    output logic                      o_pop,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic [abt_pkg::KEY_W-1:0] o_out_key,
    output abt_pkg::t_status          o_out_status,
    output logic                      o_out_last
);
    import abt_pkg::*;

    // Slot address width and width of a child index (up to 2 * TREE_NODES).
    localparam int IW = $clog2(TREE_NODES + 1);
    localparam int CW = $clog2(2 * TREE_NODES + 1);
    localparam logic [CW-1:0] NODES_C = CW'(TREE_NODES);

    // Node store and its per-slot valid bits.
    logic [KEY_W-1:0]      r_mem [TREE_NODES];
    logic [TREE_NODES-1:0] r_valid;
    logic [KEY_W-1:0]      r_rd_data;

    t_state           r_state, n_state;
    t_phase           r_phase, n_phase;
    t_cmd             r_order, n_order;
    logic [CW-1:0]    r_cur, n_cur;
    logic [KEY_W-1:0] r_key, n_key;
    logic             r_trv_done, n_trv_done;
    logic             r_pend_valid, n_pend_valid;
    logic [KEY_W-1:0] r_pend_key, n_pend_key;

    logic             r_out_valid;
    logic [KEY_W-1:0] r_out_key;
    t_status          r_out_status;
    logic             r_out_last;

    logic             out_free;
    logic             push;
    logic [KEY_W-1:0] push_key;
    t_status          push_status;
    logic             push_last;
    logic             rd_en;
    logic [IW-1:0]    rd_addr;
    logic             wr_en;

    logic             cur_full;
    logic             root_full;
    logic [CW-1:0]    left_idx;
    logic [CW-1:0]    right_idx;
    logic [CW-1:0]    parent_idx;
    logic [CW-1:0]    next_idx;
    logic             next_full;
    logic             key_less;
    logic             emit;
    logic             done;

    // A slot holds a key when it lies inside the array and has been written.
    function automatic logic slot_full(logic [CW-1:0] idx, logic [TREE_NODES-1:0] valid);
        logic in_range;
        in_range = (idx < NODES_C);
        return in_range && valid[idx[IW-1:0]];
    endfunction

    assign out_free   = !r_out_valid || i_out_ready;
    assign cur_full   = slot_full(r_cur, r_valid);
    assign root_full  = r_valid[0];
    assign left_idx   = (r_cur << 1) + CW'(1);
    assign right_idx  = (r_cur << 1) + CW'(2);
    assign parent_idx = (r_cur - CW'(1)) >> 1;
    assign key_less   = $signed(r_key) < $signed(r_rd_data);
    assign next_idx   = key_less ? left_idx : right_idx;
    assign next_full  = slot_full(next_idx, r_valid);

    // Next state, store access and result pushes.
    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_order      = r_order;
        n_cur        = r_cur;
        n_key        = r_key;
        n_trv_done   = r_trv_done;
        n_pend_valid = r_pend_valid;
        n_pend_key   = r_pend_key;
        o_pop        = 1'b0;
        push         = 1'b0;
        push_key     = '0;
        push_status  = STAT_INSERTED;
        push_last    = 1'b1;
        rd_en        = 1'b0;
        rd_addr      = r_cur[IW-1:0];
        wr_en        = 1'b0;
        emit         = 1'b0;
        done         = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    unique case (i_head.cmd) inside
                        CMD_NOP: begin
                            if (out_free) begin
                                o_pop       = 1'b1;
                                push        = 1'b1;
                                push_status = STAT_INSERTED;
                            end
                        end
                        CMD_INSERT: begin
                            o_pop = 1'b1;
                            n_key = i_head.key;
                            n_cur = '0;
                            if (root_full) begin
                                rd_en   = 1'b1;
                                rd_addr = '0;
                                n_state = S_INS_CMP;
                            end else begin
                                n_state = S_INS_WR;
                            end
                        end
                        CMD_PRE, CMD_IN, CMD_POST: begin
                            if (!root_full) begin
                                if (out_free) begin
                                    o_pop       = 1'b1;
                                    push        = 1'b1;
                                    push_status = STAT_EMPTY;
                                end
                            end else begin
                                o_pop      = 1'b1;
                                n_order    = i_head.cmd;
                                n_cur      = '0;
                                n_phase    = PH_ENTER;
                                n_trv_done = 1'b0;
                                n_state    = S_TRV_STEP;
                            end
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end

            // One tree level per cycle: compare, pick a child, read it if occupied.
            S_INS_CMP: begin
                n_cur = next_idx;
                if (next_full) begin
                    rd_en   = 1'b1;
                    rd_addr = next_idx[IW-1:0];
                end else begin
                    n_state = S_INS_WR;
                end
            end

            // Write the key into the empty slot, or report a full tree.
            S_INS_WR: begin
                if (out_free) begin
                    push = 1'b1;
                    if (r_cur < NODES_C) begin
                        wr_en       = 1'b1;
                        push_status = STAT_INSERTED;
                    end else begin
                        push_status = STAT_FULL;
                    end
                    n_state = S_IDLE;
                end
            end

            // Stackless walk: move down, across or up one slot per step.
            S_TRV_STEP: begin
                unique case (r_phase)
                    PH_ENTER: begin
                        if (!cur_full) begin
                            n_cur   = parent_idx;
                            n_phase = r_cur[0] ? PH_FROM_LEFT : PH_FROM_RIGHT;
                        end else begin
                            emit    = (r_order == CMD_PRE);
                            n_cur   = left_idx;
                            n_phase = PH_ENTER;
                        end
                    end
                    PH_FROM_LEFT: begin
                        emit    = (r_order == CMD_IN);
                        n_cur   = right_idx;
                        n_phase = PH_ENTER;
                    end
                    PH_FROM_RIGHT: begin
                        emit = (r_order == CMD_POST);
                        if (r_cur == '0) begin
                            done = 1'b1;
                        end else begin
                            n_cur   = parent_idx;
                            n_phase = r_cur[0] ? PH_FROM_LEFT : PH_FROM_RIGHT;
                        end
                    end
                    default: begin
                        done = 1'b1;
                    end
                endcase
                if (emit) begin
                    rd_en      = 1'b1;
                    rd_addr    = r_cur[IW-1:0];
                    n_trv_done = done;
                    n_state    = S_TRV_EMIT;
                end else if (done) begin
                    n_state = S_TRV_FIN;
                end
            end

            // The key read last step enters the pending slot; the older one leaves.
            S_TRV_EMIT: begin
                if (!r_pend_valid || out_free) begin
                    if (r_pend_valid) begin
                        push        = 1'b1;
                        push_key    = r_pend_key;
                        push_status = STAT_KEY;
                        push_last   = 1'b0;
                    end
                    n_pend_valid = 1'b1;
                    n_pend_key   = r_rd_data;
                    n_state      = r_trv_done ? S_TRV_FIN : S_TRV_STEP;
                end
            end

            // The held key is the final one of the traversal.
            S_TRV_FIN: begin
                if (out_free) begin
                    push         = 1'b1;
                    push_key     = r_pend_key;
                    push_status  = STAT_KEY;
                    push_last    = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_phase      <= PH_ENTER;
            r_trv_done   <= 1'b0;
            r_pend_valid <= 1'b0;
            r_valid      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_phase      <= n_phase;
            r_trv_done   <= n_trv_done;
            r_pend_valid <= n_pend_valid;
            if (wr_en) begin
                r_valid[r_cur[IW-1:0]] <= 1'b1;
            end
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_order    <= n_order;
        r_cur      <= n_cur;
        r_key      <= n_key;
        r_pend_key <= n_pend_key;
        if (push) begin
            r_out_key    <= push_key;
            r_out_status <= push_status;
            r_out_last   <= push_last;
        end
    end

    // Node store with one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_cur[IW-1:0]] <= r_key;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_key    = r_out_key;
    assign o_out_status = r_out_status;
    assign o_out_last   = r_out_last;

endmodule

// ----- hw/rtl/array_bst_insert_traverse.sv -----
// Binary search tree held in an implicit array, with insert and traversal.
// Built from abt_front and abt_back; depends on abt_pkg.
//
// Usage: the slave stream carries one command per beat. tdata holds the key,
// tuser holds the kind (bit 0: insert or traverse) and the traversal order
// (bits 2:1: preorder, inorder, postorder; the unused code acts as preorder).
// An insert gives one result beat; a traversal gives one beat per stored key
// with tlast on the final one, or a single empty-marked beat for an empty tree.
// Master tdata holds the key on traversal beats and zero otherwise, tuser the
// status, tlast marks the final beat. An insert walks the tree one level at
// a time, as the node store has a single read port. A traversal passes each
// stored key on entry, on return from the left and on return from the right,
// and enters each empty child once; each emitted key needs its own store read.
// A two-entry command queue lets new beats arrive meanwhile.
// Reset empties the tree at once through per-slot valid bits; no clearing
// pass is needed. When the receiver stalls, the result sits in the output
// register, the walk pauses and the queue fills, then tready falls.
`timescale 1ns / 1ps

module array_bst_insert_traverse #(
    parameter int TREE_NODES = abt_pkg::TREE_NODES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // key [31:0]
    input  logic [abt_pkg::KEY_W-1:0]      s_axis_tdata,
    // kind [0], order [2:1]
    input  logic [abt_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // out_key [31:0]
    output logic [abt_pkg::KEY_W-1:0]      m_axis_tdata,
    // status [1:0]
    output logic [abt_pkg::OUT_USER_W-1:0] m_axis_tuser,
    output logic                           m_axis_tlast
);
    import abt_pkg::*;

    t_queue_head head;
    logic        pop;
    t_status     out_status;

    // Accept, classify and queue commands.
    abt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_in_key   (s_axis_tdata),
        .i_in_kind  (s_axis_tuser[0]),
        .i_in_order (s_axis_tuser[IN_USER_W-1:1]),
        .o_head     (head),
        .i_pop      (pop)
    );

    // Execute commands against the node store.
    abt_back #(
        .TREE_NODES (TREE_NODES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .o_pop        (pop),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_key    (m_axis_tdata),
        .o_out_status (out_status),
        .o_out_last   (m_axis_tlast)
    );

    assign m_axis_tuser = OUT_USER_W'(out_status);

endmodule
